@@ rtl/imu_sample_unit_conversion_unit_assert.svh @@
// Assertion macros shared by the checker.
`ifndef IMU_SAMPLE_UNIT_CONVERSION_UNIT_ASSERT_SVH
`define IMU_SAMPLE_UNIT_CONVERSION_UNIT_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define IMU_CVT_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imu_cvt: same-cycle check failed");

// Next-cycle implication, gated off during reset.
`define IMU_CVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imu_cvt: next-cycle check failed");

`endif

@@ rtl/imu_cvt_pkg.sv @@
`default_nettype none

package imu_cvt_pkg;

  // Scaling constants
  localparam longint MICRO_SCALE = 1000000;
  localparam longint RATE_NUM    = 180000;
  localparam longint RATE_DEN    = 3141593;
  localparam longint RATE_MAX    = 65535;

  // Reciprocal of RATE_DEN/RATE_NUM; estimate is exact or one low for |urad| < 2^21
  localparam int     RECIP_SHIFT = 22;
  localparam longint RECIP_K     = (RATE_NUM << RECIP_SHIFT) / RATE_DEN;

  // Smallest |urad| whose converted rate no longer fits in 16 bits
  localparam longint SAT_URAD = ((RATE_MAX + 1) * RATE_DEN + RATE_NUM - 1) / RATE_NUM;

  // Pipeline shape
  localparam int AXES           = 3;
  localparam int LANE_STAGES    = 5;
  localparam int SQRT_ITERS     = 16;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = SQRT_ITERS / SQRT_PER_STAGE;
  localparam int MERGE_STAGES   = 1 + SQRT_STAGES;
  localparam int NSTG           = LANE_STAGES + MERGE_STAGES;

  typedef logic [LANE_STAGES-1:0]  lane_en_t;
  typedef logic [MERGE_STAGES-1:0] merge_en_t;
  typedef logic [NSTG-1:0]         stage_en_t;

  // Payload and datapath types
  typedef logic signed [8:0]  accel_whole_t;
  typedef logic signed [7:0]  gyro_whole_t;
  typedef logic signed [20:0] micro_t;
  typedef logic signed [28:0] accel_t;
  typedef logic signed [28:0] urad_t;
  typedef logic [27:0]        uabs_t;
  typedef logic [20:0]        absu_t;
  typedef logic [38:0]        prod_t;
  typedef logic [15:0]        rate_t;
  typedef logic [31:0]        sq_t;
  typedef logic [33:0]        sum_t;

endpackage

`default_nettype wire

@@ rtl/imu_cvt_rate_lane.sv @@
`default_nettype none

// One gyro axis: urad -> |mdeg/s| saturated, then its square.
module imu_cvt_rate_lane (
  input  logic                       clk,
  input  imu_cvt_pkg::lane_en_t      en,
  input  imu_cvt_pkg::gyro_whole_t   whole,
  input  imu_cvt_pkg::micro_t        micro,
  output imu_cvt_pkg::rate_t         rate,
  output imu_cvt_pkg::sq_t           sq
);

  imu_cvt_pkg::urad_t whole_ext;
  imu_cvt_pkg::urad_t micro_ext;
  imu_cvt_pkg::urad_t urad;
  imu_cvt_pkg::uabs_t uabs;
  imu_cvt_pkg::rate_t qe_est;
  imu_cvt_pkg::prod_t rem;

  imu_cvt_pkg::absu_t s0_absu;
  logic               s0_sat;
  imu_cvt_pkg::prod_t s1_pk;
  imu_cvt_pkg::prod_t s1_pn;
  logic               s1_sat;
  imu_cvt_pkg::rate_t s2_qe;
  imu_cvt_pkg::prod_t s2_qd;
  imu_cvt_pkg::prod_t s2_pn;
  logic               s2_sat;
  imu_cvt_pkg::rate_t s3_rate;
  imu_cvt_pkg::rate_t s4_rate;
  imu_cvt_pkg::sq_t   s4_sq;

  assign whole_ext = imu_cvt_pkg::urad_t'(whole);
  assign micro_ext = imu_cvt_pkg::urad_t'(micro);
  assign urad      = whole_ext * imu_cvt_pkg::urad_t'(imu_cvt_pkg::MICRO_SCALE) + micro_ext;
  // quotient truncates toward zero, so work on the magnitude
  assign uabs      = imu_cvt_pkg::uabs_t'(urad[28] ? -urad : urad);

  assign qe_est = imu_cvt_pkg::rate_t'(s1_pk >> imu_cvt_pkg::RECIP_SHIFT);
  assign rem    = s2_pn - s2_qd;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_absu <= imu_cvt_pkg::absu_t'(uabs);
      s0_sat  <= uabs >= imu_cvt_pkg::uabs_t'(imu_cvt_pkg::SAT_URAD);
    end
    if (en[1]) begin
      s1_pk  <= imu_cvt_pkg::prod_t'(s0_absu) * imu_cvt_pkg::prod_t'(imu_cvt_pkg::RECIP_K);
      s1_pn  <= imu_cvt_pkg::prod_t'(s0_absu) * imu_cvt_pkg::prod_t'(imu_cvt_pkg::RATE_NUM);
      s1_sat <= s0_sat;
    end
    if (en[2]) begin
      s2_qe  <= qe_est;
      s2_qd  <= imu_cvt_pkg::prod_t'(qe_est) * imu_cvt_pkg::prod_t'(imu_cvt_pkg::RATE_DEN);
      s2_pn  <= s1_pn;
      s2_sat <= s1_sat;
    end
    if (en[3]) begin
      // estimate is at most one low; one compare fixes it
      s3_rate <= s2_sat ? imu_cvt_pkg::rate_t'(imu_cvt_pkg::RATE_MAX)
                        : s2_qe + imu_cvt_pkg::rate_t'(
                            rem >= imu_cvt_pkg::prod_t'(imu_cvt_pkg::RATE_DEN));
    end
    if (en[4]) begin
      s4_rate <= s3_rate;
      s4_sq   <= imu_cvt_pkg::sq_t'(s3_rate) * imu_cvt_pkg::sq_t'(s3_rate);
    end
  end

  assign rate = s4_rate;
  assign sq   = s4_sq;

endmodule

`default_nettype wire

@@ rtl/imu_cvt_merge.sv @@
`default_nettype none

// Sum of squares from the lanes, then a pipelined floor square root.
module imu_cvt_merge (
  input  logic                    clk,
  input  imu_cvt_pkg::merge_en_t  en,
  input  imu_cvt_pkg::sq_t        sq_x,
  input  imu_cvt_pkg::sq_t        sq_y,
  input  imu_cvt_pkg::sq_t        sq_z,
  output imu_cvt_pkg::rate_t      magnitude
);

  typedef struct packed {
    imu_cvt_pkg::sq_t rem;
    imu_cvt_pkg::sq_t root;
    logic             sat;
  } sqrt_t;

  function automatic sqrt_t sqrt_stage(input sqrt_t s_in, input int stage);
    sqrt_t       s;
    logic [32:0] trial;
    logic [4:0]  sh;
    s = s_in;
    for (int j = 0; j < imu_cvt_pkg::SQRT_PER_STAGE; j++) begin
      sh = 5'(2 * (imu_cvt_pkg::SQRT_ITERS - 1)
              - 2 * (imu_cvt_pkg::SQRT_PER_STAGE * stage + j));
      trial = {1'b0, s.root} + (33'd1 << sh);
      if ({1'b0, s.rem} >= trial) begin
        s.rem  = s.rem - trial[31:0];
        s.root = (s.root >> 1) + (32'd1 << sh);
      end else begin
        s.root = s.root >> 1;
      end
    end
    return s;
  endfunction

  imu_cvt_pkg::sum_t sum_q;
  sqrt_t             init;
  sqrt_t             stg   [imu_cvt_pkg::SQRT_STAGES];
  sqrt_t             stg_d [imu_cvt_pkg::SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_q <= imu_cvt_pkg::sum_t'(sq_x) + imu_cvt_pkg::sum_t'(sq_y)
             + imu_cvt_pkg::sum_t'(sq_z);
    end
  end

  // any sum at or above 2^32 has a root above 65535
  assign init = '{rem: sum_q[31:0], root: '0, sat: |sum_q[33:32]};

  for (genvar g = 0; g < imu_cvt_pkg::SQRT_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign stg_d[g] = sqrt_stage(init, g);
    end else begin : g_rest
      assign stg_d[g] = sqrt_stage(stg[g-1], g);
    end
    always_ff @(posedge clk) begin
      if (en[g+1]) begin
        stg[g] <= stg_d[g];
      end
    end
  end

  assign magnitude = stg[imu_cvt_pkg::SQRT_STAGES-1].sat
                   ? imu_cvt_pkg::rate_t'(imu_cvt_pkg::RATE_MAX)
                   : imu_cvt_pkg::rate_t'(stg[imu_cvt_pkg::SQRT_STAGES-1].root);

endmodule

`default_nettype wire

@@ rtl/imu_sample_unit_conversion_unit.sv @@
// 14 register stages from the accepting edge to out_valid.
// Throughput: one transaction per cycle while out_ready is high; every stage is a fully pipelined step.
// Depth is set by the gyro lanes (5 stages: scale, two multiplier ranks, fix-up,
// square) plus the merge (sum, then 8 root stages resolving 2 bits each).
// Reset clears the stage valid bits only and holds in_ready low; datapath is not reset.
`default_nettype none

module imu_sample_unit_conversion_unit (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  imu_cvt_pkg::accel_whole_t    accel_x_whole,
  input  imu_cvt_pkg::micro_t          accel_x_micro,
  input  imu_cvt_pkg::accel_whole_t    accel_y_whole,
  input  imu_cvt_pkg::micro_t          accel_y_micro,
  input  imu_cvt_pkg::accel_whole_t    accel_z_whole,
  input  imu_cvt_pkg::micro_t          accel_z_micro,
  input  imu_cvt_pkg::gyro_whole_t     gyro_x_whole,
  input  imu_cvt_pkg::micro_t          gyro_x_micro,
  input  imu_cvt_pkg::gyro_whole_t     gyro_y_whole,
  input  imu_cvt_pkg::micro_t          gyro_y_micro,
  input  imu_cvt_pkg::gyro_whole_t     gyro_z_whole,
  input  imu_cvt_pkg::micro_t          gyro_z_micro,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output imu_cvt_pkg::accel_t          accel_x_out,
  output imu_cvt_pkg::accel_t          accel_y_out,
  output imu_cvt_pkg::accel_t          accel_z_out,
  output imu_cvt_pkg::rate_t           rate_x_mdeg,
  output imu_cvt_pkg::rate_t           rate_y_mdeg,
  output imu_cvt_pkg::rate_t           rate_z_mdeg,
  output imu_cvt_pkg::rate_t           rate_magnitude
);

  // ------------------------------------------------------------------
  // Stage control. Each stage has a valid bit; a stage loads when it is
  // empty or when the stage after it loads, so bubbles collapse; while a
  // result waits at the output, transactions enter while a stage is empty.
  // ------------------------------------------------------------------
  imu_cvt_pkg::stage_en_t vld;
  imu_cvt_pkg::stage_en_t vld_shift;
  imu_cvt_pkg::stage_en_t en;

  always_comb begin
    en[imu_cvt_pkg::NSTG-1] = !vld[imu_cvt_pkg::NSTG-1] || out_ready;
    for (int k = imu_cvt_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_shift = {vld[imu_cvt_pkg::NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld_shift & en) | (vld & ~en);
    end
  end

  // no transaction is taken while reset is held
  assign in_ready  = en[0] && !rst;
  assign out_valid = vld[imu_cvt_pkg::NSTG-1];

  // ------------------------------------------------------------------
  // Acceleration: whole*1e6 + micro, then carried alongside the rate path.
  // Result always fits 29 signed bits, no saturation needed.
  // ------------------------------------------------------------------
  imu_cvt_pkg::accel_whole_t aw       [imu_cvt_pkg::AXES];
  imu_cvt_pkg::micro_t       am       [imu_cvt_pkg::AXES];
  imu_cvt_pkg::accel_t       acc_in   [imu_cvt_pkg::AXES];
  imu_cvt_pkg::accel_t       acc_pipe [imu_cvt_pkg::NSTG][imu_cvt_pkg::AXES];

  assign aw[0] = accel_x_whole;
  assign aw[1] = accel_y_whole;
  assign aw[2] = accel_z_whole;
  assign am[0] = accel_x_micro;
  assign am[1] = accel_y_micro;
  assign am[2] = accel_z_micro;

  for (genvar a = 0; a < imu_cvt_pkg::AXES; a++) begin : g_acc_conv
    assign acc_in[a] = imu_cvt_pkg::accel_t'(aw[a])
                     * imu_cvt_pkg::accel_t'(imu_cvt_pkg::MICRO_SCALE)
                     + imu_cvt_pkg::accel_t'(am[a]);
  end

  for (genvar k = 0; k < imu_cvt_pkg::NSTG; k++) begin : g_acc_pipe
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[k]) begin
          acc_pipe[k] <= acc_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[k]) begin
          acc_pipe[k] <= acc_pipe[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Gyro lanes: one per axis, all in lockstep on the lane enables.
  // ------------------------------------------------------------------
  imu_cvt_pkg::gyro_whole_t gw        [imu_cvt_pkg::AXES];
  imu_cvt_pkg::micro_t      gm        [imu_cvt_pkg::AXES];
  imu_cvt_pkg::rate_t       lane_rate [imu_cvt_pkg::AXES];
  imu_cvt_pkg::sq_t         lane_sq   [imu_cvt_pkg::AXES];

  assign gw[0] = gyro_x_whole;
  assign gw[1] = gyro_y_whole;
  assign gw[2] = gyro_z_whole;
  assign gm[0] = gyro_x_micro;
  assign gm[1] = gyro_y_micro;
  assign gm[2] = gyro_z_micro;

  for (genvar a = 0; a < imu_cvt_pkg::AXES; a++) begin : g_lane
    imu_cvt_rate_lane u_lane (
      .clk   (clk),
      .en    (en[imu_cvt_pkg::LANE_STAGES-1:0]),
      .whole (gw[a]),
      .micro (gm[a]),
      .rate  (lane_rate[a]),
      .sq    (lane_sq[a])
    );
  end

  // Per-axis rates ride along the merge stages
  imu_cvt_pkg::rate_t rate_pipe [imu_cvt_pkg::MERGE_STAGES][imu_cvt_pkg::AXES];

  for (genvar m = 0; m < imu_cvt_pkg::MERGE_STAGES; m++) begin : g_rate_pipe
    if (m == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[imu_cvt_pkg::LANE_STAGES + m]) begin
          rate_pipe[m] <= lane_rate;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[imu_cvt_pkg::LANE_STAGES + m]) begin
          rate_pipe[m] <= rate_pipe[m-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Merge: sum of squares and saturated floor square root.
  // ------------------------------------------------------------------
  imu_cvt_merge u_merge (
    .clk       (clk),
    .en        (en[imu_cvt_pkg::NSTG-1:imu_cvt_pkg::LANE_STAGES]),
    .sq_x      (lane_sq[0]),
    .sq_y      (lane_sq[1]),
    .sq_z      (lane_sq[2]),
    .magnitude (rate_magnitude)
  );

  assign accel_x_out = acc_pipe[imu_cvt_pkg::NSTG-1][0];
  assign accel_y_out = acc_pipe[imu_cvt_pkg::NSTG-1][1];
  assign accel_z_out = acc_pipe[imu_cvt_pkg::NSTG-1][2];
  assign rate_x_mdeg = rate_pipe[imu_cvt_pkg::MERGE_STAGES-1][0];
  assign rate_y_mdeg = rate_pipe[imu_cvt_pkg::MERGE_STAGES-1][1];
  assign rate_z_mdeg = rate_pipe[imu_cvt_pkg::MERGE_STAGES-1][2];

endmodule

`default_nettype wire

@@ rtl/imu_cvt_checker.sv @@
`default_nettype none
`include "imu_sample_unit_conversion_unit_assert.svh"

module imu_cvt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input imu_cvt_pkg::rate_t rate_x_mdeg,
  input imu_cvt_pkg::rate_t rate_y_mdeg,
  input imu_cvt_pkg::rate_t rate_z_mdeg,
  input imu_cvt_pkg::rate_t rate_magnitude
);

  // stalled result stays put
  `IMU_CVT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(rate_magnitude))

  // root of the sum never falls below any single axis
  `IMU_CVT_ASSERT(a_mag_ge_axes, clk, rst, out_valid, rate_magnitude >= rate_x_mdeg && rate_magnitude >= rate_y_mdeg && rate_magnitude >= rate_z_mdeg)

  // with only the x axis moving the magnitude is that axis
  `IMU_CVT_ASSERT(a_mag_single, clk, rst, out_valid && rate_y_mdeg == 16'd0 && rate_z_mdeg == 16'd0, rate_magnitude == rate_x_mdeg)

  // an empty output stage means the pipe can take a transaction
  `IMU_CVT_ASSERT(a_ready_when_empty, clk, rst, !out_valid, in_ready)

endmodule

bind imu_sample_unit_conversion_unit imu_cvt_checker u_imu_cvt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .rate_x_mdeg    (rate_x_mdeg),
  .rate_y_mdeg    (rate_y_mdeg),
  .rate_z_mdeg    (rate_z_mdeg),
  .rate_magnitude (rate_magnitude)
);

`default_nettype wire

@@ sim/imu_conversion_checker.sv @@
module imu_conversion_checker
  import imu_cvt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_ready,
  input  accel_whole_t accel_x_whole,
  input  micro_t       accel_x_micro,
  input  accel_whole_t accel_y_whole,
  input  micro_t       accel_y_micro,
  input  accel_whole_t accel_z_whole,
  input  micro_t       accel_z_micro,
  input  gyro_whole_t  gyro_x_whole,
  input  micro_t       gyro_x_micro,
  input  gyro_whole_t  gyro_y_whole,
  input  micro_t       gyro_y_micro,
  input  gyro_whole_t  gyro_z_whole,
  input  micro_t       gyro_z_micro,
  input  logic         out_valid,
  input  logic         out_ready,
  input  accel_t       accel_x_out,
  input  accel_t       accel_y_out,
  input  accel_t       accel_z_out,
  input  rate_t        rate_x_mdeg,
  input  rate_t        rate_y_mdeg,
  input  rate_t        rate_z_mdeg,
  input  rate_t        rate_magnitude,
  output int           mismatch_count,
  output int           pending_count,
  output int           checked_count
);

  typedef struct packed {
    accel_t accel_x;
    accel_t accel_y;
    accel_t accel_z;
    rate_t  rate_x;
    rate_t  rate_y;
    rate_t  rate_z;
    rate_t  magnitude;
  } conversion_t;

  conversion_t expected_conversions[$];
  int errors  = 0;
  int checked = 0;
  int pending = 0;

  assign mismatch_count = errors;
  assign pending_count  = pending;
  assign checked_count  = checked;

  function automatic accel_t accel_micro(accel_whole_t whole, micro_t micro);
    longint total;
    total = longint'(whole) * MICRO_SCALE + longint'(micro);
    return total[28:0];
  endfunction

  // truncating divide, then magnitude clipped to 16 bits
  function automatic rate_t rate_mdeg_abs(gyro_whole_t whole, micro_t micro);
    longint urad;
    longint mdeg;
    urad = longint'(whole) * MICRO_SCALE + longint'(micro);
    mdeg = (urad * RATE_NUM) / RATE_DEN;
    if (mdeg < 0) mdeg = -mdeg;
    if (mdeg > RATE_MAX) mdeg = RATE_MAX;
    return mdeg[15:0];
  endfunction

  function automatic conversion_t convert_sample(
    accel_whole_t axw, micro_t axm, accel_whole_t ayw, micro_t aym,
    accel_whole_t azw, micro_t azm, gyro_whole_t gxw, micro_t gxm,
    gyro_whole_t gyw, micro_t gym, gyro_whole_t gzw, micro_t gzm);
    conversion_t     c;
    longint unsigned sum_sq;
    longint unsigned trial;
    logic [16:0]     root;
    c.accel_x = accel_micro(axw, axm);
    c.accel_y = accel_micro(ayw, aym);
    c.accel_z = accel_micro(azw, azm);
    c.rate_x  = rate_mdeg_abs(gxw, gxm);
    c.rate_y  = rate_mdeg_abs(gyw, gym);
    c.rate_z  = rate_mdeg_abs(gzw, gzm);
    sum_sq = 64'(c.rate_x) * 64'(c.rate_x) + 64'(c.rate_y) * 64'(c.rate_y)
           + 64'(c.rate_z) * 64'(c.rate_z);
    // bitwise floor root; result stays below 2^17 for three 16-bit rates
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = 64'(root | (17'd1 << b));
      if (trial * trial <= sum_sq) root = trial[16:0];
    end
    c.magnitude = (root > 17'(RATE_MAX)) ? rate_t'(RATE_MAX) : root[15:0];
    return c;
  endfunction

  function automatic string show(conversion_t c);
    return $sformatf("accel %0d %0d %0d  rate %0d %0d %0d  mag %0d",
                     c.accel_x, c.accel_y, c.accel_z,
                     c.rate_x, c.rate_y, c.rate_z, c.magnitude);
  endfunction

  always @(posedge clk) begin
    conversion_t got;
    conversion_t want;
    if (!rst) begin
      // check outputs before pushing, so a combinational echo of the input cannot self-match
      if (out_valid && out_ready) begin
        got.accel_x   = accel_x_out;
        got.accel_y   = accel_y_out;
        got.accel_z   = accel_z_out;
        got.rate_x    = rate_x_mdeg;
        got.rate_y    = rate_y_mdeg;
        got.rate_z    = rate_z_mdeg;
        got.magnitude = rate_magnitude;
        if (expected_conversions.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result transaction: %s", $time, show(got));
          errors++;
        end else begin
          want = expected_conversions.pop_front();
          checked++;
          if (got !== want) begin
            if (errors < 10) begin
              $display("%0t: result %0d mismatch", $time, checked);
              $display("  got  %s", show(got));
              $display("  want %s", show(want));
            end
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_conversions.push_back(convert_sample(
          accel_x_whole, accel_x_micro, accel_y_whole, accel_y_micro,
          accel_z_whole, accel_z_micro, gyro_x_whole, gyro_x_micro,
          gyro_y_whole, gyro_y_micro, gyro_z_whole, gyro_z_micro));
      pending = expected_conversions.size();
    end
  end

endmodule

@@ sim/imu_sample_unit_conversion_unit_test.sv @@
module imu_sample_unit_conversion_unit_test;
  import imu_cvt_pkg::*;

  // Random items after the directed set, split over three throttle phases.
  localparam int RANDOM_ITEMS = 1934;
  localparam int PHASE_ITEMS  = 645;
  // Cycles to wait after the last result.
  localparam int DRAIN_CYCLES = 40;
  // Long output hold-off: far deeper than the 14-stage pipeline.
  localparam int STALL_CYCLES = 300;
  // Cycles without any transaction before the run is declared hung.
  localparam int QUIET_LIMIT  = 3000;

  typedef struct {
    accel_whole_t axw;
    micro_t       axm;
    accel_whole_t ayw;
    micro_t       aym;
    accel_whole_t azw;
    micro_t       azm;
    gyro_whole_t  gxw;
    micro_t       gxm;
    gyro_whole_t  gyw;
    micro_t       gym;
    gyro_whole_t  gzw;
    micro_t       gzm;
  } imu_sample_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_ready;
  accel_whole_t accel_x_whole, accel_y_whole, accel_z_whole;
  micro_t       accel_x_micro, accel_y_micro, accel_z_micro;
  gyro_whole_t  gyro_x_whole, gyro_y_whole, gyro_z_whole;
  micro_t       gyro_x_micro, gyro_y_micro, gyro_z_micro;
  logic         out_valid;
  logic         out_ready;
  accel_t       accel_x_out, accel_y_out, accel_z_out;
  rate_t        rate_x_mdeg, rate_y_mdeg, rate_z_mdeg, rate_magnitude;

  int mismatches;
  int pending;
  int checked;

  // Throttle knobs, percent of cycles each side idles.
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  // Set once by the stimulus; the receiver runs the hold-off itself.
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int sent      = 0;
  int quiet     = 0;

  imu_sample_unit_conversion_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .accel_x_whole  (accel_x_whole),
    .accel_x_micro  (accel_x_micro),
    .accel_y_whole  (accel_y_whole),
    .accel_y_micro  (accel_y_micro),
    .accel_z_whole  (accel_z_whole),
    .accel_z_micro  (accel_z_micro),
    .gyro_x_whole   (gyro_x_whole),
    .gyro_x_micro   (gyro_x_micro),
    .gyro_y_whole   (gyro_y_whole),
    .gyro_y_micro   (gyro_y_micro),
    .gyro_z_whole   (gyro_z_whole),
    .gyro_z_micro   (gyro_z_micro),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accel_x_out    (accel_x_out),
    .accel_y_out    (accel_y_out),
    .accel_z_out    (accel_z_out),
    .rate_x_mdeg    (rate_x_mdeg),
    .rate_y_mdeg    (rate_y_mdeg),
    .rate_z_mdeg    (rate_z_mdeg),
    .rate_magnitude (rate_magnitude)
  );

  // Passive: sees both channels, predicts each transaction, compares.
  imu_conversion_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .accel_x_whole  (accel_x_whole),
    .accel_x_micro  (accel_x_micro),
    .accel_y_whole  (accel_y_whole),
    .accel_y_micro  (accel_y_micro),
    .accel_z_whole  (accel_z_whole),
    .accel_z_micro  (accel_z_micro),
    .gyro_x_whole   (gyro_x_whole),
    .gyro_x_micro   (gyro_x_micro),
    .gyro_y_whole   (gyro_y_whole),
    .gyro_y_micro   (gyro_y_micro),
    .gyro_z_whole   (gyro_z_whole),
    .gyro_z_micro   (gyro_z_micro),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accel_x_out    (accel_x_out),
    .accel_y_out    (accel_y_out),
    .accel_z_out    (accel_z_out),
    .rate_x_mdeg    (rate_x_mdeg),
    .rate_y_mdeg    (rate_y_mdeg),
    .rate_z_mdeg    (rate_z_mdeg),
    .rate_magnitude (rate_magnitude),
    .mismatch_count (mismatches),
    .pending_count  (pending),
    .checked_count  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Argument order: accel x/y/z (whole, micro), then gyro x/y/z (whole, micro).
  function automatic imu_sample_t make_sample(
    int axw, int axm, int ayw, int aym, int azw, int azm,
    int gxw, int gxm, int gyw, int gym, int gzw, int gzm);
    imu_sample_t s;
    s.axw = accel_whole_t'(axw);
    s.axm = micro_t'(axm);
    s.ayw = accel_whole_t'(ayw);
    s.aym = micro_t'(aym);
    s.azw = accel_whole_t'(azw);
    s.azm = micro_t'(azm);
    s.gxw = gyro_whole_t'(gxw);
    s.gxm = micro_t'(gxm);
    s.gyw = gyro_whole_t'(gyw);
    s.gym = micro_t'(gym);
    s.gzw = gyro_whole_t'(gzw);
    s.gzm = micro_t'(gzm);
    return s;
  endfunction

  // Mostly in range; a slice uses the full 21-bit field so every bit toggles.
  function automatic int pick_micro();
    case ($urandom_range(9))
      0: return int'($urandom_range(2097151)) - 1048576;
      1: return $urandom_range(1) ? 999999 : -999999;
      default: return int'($urandom_range(1999998)) - 999999;
    endcase
  endfunction

  function automatic int pick_accel_whole();
    case ($urandom_range(9))
      0: return int'($urandom_range(511)) - 256;
      1: return $urandom_range(1) ? 160 : -160;
      default: return int'($urandom_range(320)) - 160;
    endcase
  endfunction

  // Rates clip above about 1.14 rad/s, so most draws stay near zero to
  // exercise the unclipped division and the root; the rest hit the clip.
  function automatic int pick_gyro_whole();
    case ($urandom_range(9))
      0: return int'($urandom_range(255)) - 128;
      1: return $urandom_range(1) ? 64 : -64;
      2, 3: return int'($urandom_range(128)) - 64;
      default: return int'($urandom_range(4)) - 2;
    endcase
  endfunction

  function automatic imu_sample_t random_sample();
    return make_sample(pick_accel_whole(), pick_micro(), pick_accel_whole(), pick_micro(),
                       pick_accel_whole(), pick_micro(), pick_gyro_whole(), pick_micro(),
                       pick_gyro_whole(), pick_micro(), pick_gyro_whole(), pick_micro());
  endfunction

  task automatic drive_fields(imu_sample_t s);
    accel_x_whole <= s.axw;
    accel_x_micro <= s.axm;
    accel_y_whole <= s.ayw;
    accel_y_micro <= s.aym;
    accel_z_whole <= s.azw;
    accel_z_micro <= s.azm;
    gyro_x_whole  <= s.gxw;
    gyro_x_micro  <= s.gxm;
    gyro_y_whole  <= s.gyw;
    gyro_y_micro  <= s.gym;
    gyro_z_whole  <= s.gzw;
    gyro_z_micro  <= s.gzm;
  endtask

  // Called right after a rising edge. Optional idle cycles first, then the
  // sample is held until a transaction. Ready is looked at on the falling
  // edge, where it is settled for the coming rising edge.
  task automatic offer_sample(imu_sample_t s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drive_fields(s);
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  // Receiver: random back-pressure, plus one long hold-off when asked.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    imu_sample_t directed[$];
    rst      <= 1'b1;
    in_valid <= 1'b0;
    drive_fields(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // all zero
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // accel range extremes, tiny positive micro
    directed.push_back(make_sample(160, 999999, -160, -999999, 0, 1,
                                   0, 0, 0, 0, 0, 0));
    // accel full-width extremes; rate rounding right at 0/1 mdeg/s
    directed.push_back(make_sample(255, 1048575, -256, -1048576, 255, -1048576,
                                   0, 17, 0, 18, 0, -18));
    // whole and micro of opposite sign, no normalization
    directed.push_back(make_sample(-256, 1048575, 3, -500000, -1, 999999,
                                   1, -999999, -1, 999999, 0, -17));
    // every gyro axis clipped, magnitude clipped
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0,
                                   64, 999999, 64, 999999, 64, 999999));
    directed.push_back(make_sample(-1, -1, 1, 1, 0, -1,
                                   -64, -999999, -64, -999999, -64, -999999));
    // gyro full-width extremes
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0,
                                   127, 1048575, -128, -1048576, -128, 1048575));
    // around the 16-bit rate clip point
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0,
                                   1, 143800, 1, 143819, -1, -143820));
    // x rate clipped, magnitude exactly at full scale with no root clip
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0, 0));
    // root just under and just over 65536
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0, 2, 0, 0, 6280, 0, 0));
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0, -2, 0, 0, -6336, 0, 0));
    // 3-4-5 rates
    directed.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 53, 0, -70, 0, 0));
    // moderate mixed rates
    directed.push_back(make_sample(-160, 0, 160, 0, 0, 999999,
                                   0, 500000, -1, 250000, 0, -999999));
    // single-unit micro values of both signs
    directed.push_back(make_sample(0, -1, 0, 1, -1, 0, 0, -1, 0, 1, 0, 0));
    // whole rad/s, each axis about 57 deg/s, root clipped
    directed.push_back(make_sample(1, 0, -1, 0, 0, 0, 1, 0, -1, 0, 1, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) offer_sample(directed[i]);

    // sender light, receiver heavy
    in_idle_pct  = 23;
    out_idle_pct = 62;
    repeat (PHASE_ITEMS) offer_sample(random_sample());

    // sender heavy, receiver light
    in_idle_pct  = 62;
    out_idle_pct = 23;
    repeat (PHASE_ITEMS) offer_sample(random_sample());

    // full rate both sides; the hold-off lets the pipe fill and push back
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = 1'b1;
    repeat (RANDOM_ITEMS - 2 * PHASE_ITEMS) offer_sample(random_sample());

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // catch any stray result after the queue empties
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d samples (%0d directed), %0d results checked.",
             sent, directed.size(), checked);
    $display("Covered two throttle mixes, full rate, and a %0d-cycle output stall.",
             STALL_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/imu_cvt_pkg.sv
rtl/imu_cvt_rate_lane.sv
rtl/imu_cvt_merge.sv
rtl/imu_sample_unit_conversion_unit.sv
rtl/imu_cvt_checker.sv
sim/imu_conversion_checker.sv
sim/imu_sample_unit_conversion_unit_test.sv
